// File: sv/hjcsp_pkg.sv
`timescale 1ns / 1ps

package hjcsp_pkg;

   // Parse phases
   typedef enum logic [2:0] {
      PH_PREFIX = 3'd0,
      PH_HEADER = 3'd1,
      PH_JSON   = 3'd2,
      PH_CSV    = 3'd3,
      PH_DONE   = 3'd4,
      PH_HALT   = 3'd5
   } phase_type;

   // Position within one key/value pair of a transaction object
   typedef enum logic [1:0] {
      CSV_KEY_OPEN = 2'd0,
      CSV_IN_KEY   = 2'd1,
      CSV_COLON    = 2'd2,
      CSV_IN_VALUE = 2'd3
   } csv_phase_type;

   // How the current value ends
   localparam logic [1:0] VALUE_END_NONE  = 2'd0;
   localparam logic [1:0] VALUE_END_QUOTE = 2'd1;
   localparam logic [1:0] VALUE_END_COMMA = 2'd2;

   // Last match positions of the three literals
   localparam logic [4:0] PREFIX_LAST = 5'd8;
   localparam logic [4:0] BLANK_LAST  = 5'd3;
   localparam logic [4:0] MARKER_LAST = 5'd16;

   // Field numbering inside a record
   localparam logic [2:0] FIELD_DROPPED = 3'd1;
   localparam logic [2:0] FIELD_LAST    = 3'd5;
   localparam logic [2:0] FIELD_NEWLINE = 3'd6;

   // Characters
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   // Result queue
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_AW    = 3;
   localparam int MAX_RESULTS = 4;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       channel;
      logic       status;
      logic       last;
   } rsp_entry_type;

   // "HTTP/1.1 "
   function automatic logic [7:0] prefix_char(input logic [4:0] pos);
      logic [7:0] ch;
      case (pos)
         5'd0:    ch = 8'h48;
         5'd1:    ch = 8'h54;
         5'd2:    ch = 8'h54;
         5'd3:    ch = 8'h50;
         5'd4:    ch = 8'h2F;
         5'd5:    ch = 8'h31;
         5'd6:    ch = 8'h2E;
         5'd7:    ch = 8'h31;
         default: ch = 8'h20;
      endcase
      return ch;
   endfunction

   // CR LF CR LF
   function automatic logic [7:0] blank_char(input logic [4:0] pos);
      return pos[0] ? 8'h0A : 8'h0D;
   endfunction

   // ,"transactions":[
   function automatic logic [7:0] marker_char(input logic [4:0] pos);
      logic [7:0] ch;
      case (pos)
         5'd0:    ch = 8'h2C;
         5'd1:    ch = 8'h22;
         5'd2:    ch = 8'h74;
         5'd3:    ch = 8'h72;
         5'd4:    ch = 8'h61;
         5'd5:    ch = 8'h6E;
         5'd6:    ch = 8'h73;
         5'd7:    ch = 8'h61;
         5'd8:    ch = 8'h63;
         5'd9:    ch = 8'h74;
         5'd10:   ch = 8'h69;
         5'd11:   ch = 8'h6F;
         5'd12:   ch = 8'h6E;
         5'd13:   ch = 8'h73;
         5'd14:   ch = 8'h22;
         5'd15:   ch = 8'h3A;
         default: ch = 8'h5B;
      endcase
      return ch;
   endfunction

endpackage

// File: sv/http_json_to_csv_stream_parser.sv
`timescale 1ns / 1ps

// Channel   Ports                                   Direction
// req       req_valid/req_ready, req_in_byte        in, one response byte per transfer
// rsp       rsp_valid/rsp_ready, rsp_out_byte,      out, one character per transfer
//           rsp_channel, rsp_status, rsp_last
//
// Each accepted byte's results (up to four) are computed combinationally and written
// into an eight-entry result queue; one result leaves per cycle while rsp_ready is high.
// req_ready is high while the queue has room for four results, so bytes flow back to back
// as long as the sink keeps up; bursts at the array marker are absorbed by the queue.
// Synchronous active-high reset returns the parser to the status prefix check and empties
// the queue. A stalled sink fills the queue beyond four results and so holds req_ready low.
module http_json_to_csv_stream_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_channel,
   output logic       rsp_status,
   output logic       rsp_last
);

   localparam int AW = hjcsp_pkg::QUEUE_AW;

   // Parser state
   hjcsp_pkg::phase_type     phase_ff, phase_in;
   logic [4:0]               match_ff, match_in;
   logic [2:0]               field_ff, field_in;
   hjcsp_pkg::csv_phase_type csv_phase_ff, csv_phase_in;
   logic [1:0]               value_end_ff, value_end_in;
   logic                     esc_ff, esc_in;

   // Results of the current byte
   hjcsp_pkg::rsp_entry_type res [hjcsp_pkg::MAX_RESULTS];
   logic [2:0]               res_count;
   logic [2:0]               push_count;

   // Result queue
   hjcsp_pkg::rsp_entry_type queue_mem [hjcsp_pkg::QUEUE_DEPTH];
   logic [AW-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [AW:0]              count_ff, count_in;
   logic [AW-1:0]            wr_addr [hjcsp_pkg::MAX_RESULTS];

   logic req_accept;
   logic rsp_pop;

   assign req_ready  = (count_ff <= (AW+1)'(hjcsp_pkg::QUEUE_DEPTH - hjcsp_pkg::MAX_RESULTS));
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = (count_ff != '0);
   assign rsp_pop    = rsp_valid && rsp_ready;

   // Per-byte parse: next state and results
   always_comb begin
      logic [7:0] c;
      logic       pre_emit;
      logic [7:0] pre_byte;
      logic [7:0] o;
      logic       o_emit;
      logic [7:0] stop;
      logic       hit;

      c        = req_in_byte;
      pre_emit = 1'b0;
      pre_byte = '0;
      o        = '0;
      o_emit   = 1'b0;
      stop     = '0;
      hit      = 1'b0;

      phase_in     = phase_ff;
      match_in     = match_ff;
      field_in     = field_ff;
      csv_phase_in = csv_phase_ff;
      value_end_in = value_end_ff;
      esc_in       = esc_ff;

      res_count = '0;
      for (int k = 0; k < hjcsp_pkg::MAX_RESULTS; k++) begin
         res[k] = '0;
      end

      unique case (phase_ff)
         hjcsp_pkg::PH_PREFIX: begin
            hit = (match_ff <= hjcsp_pkg::PREFIX_LAST) &&
                  (c == hjcsp_pkg::prefix_char(match_ff));
            if (!hit) begin
               res[0].status = 1'b1;
               res_count     = 3'd1;
               phase_in      = hjcsp_pkg::PH_HALT;
            end else if (match_ff == hjcsp_pkg::PREFIX_LAST) begin
               match_in = '0;
               phase_in = hjcsp_pkg::PH_HEADER;
            end else begin
               match_in = match_ff + 5'd1;
            end
         end
         hjcsp_pkg::PH_HEADER: begin
            hit = (match_ff <= hjcsp_pkg::BLANK_LAST) &&
                  (c == hjcsp_pkg::blank_char(match_ff));
            if (!hit) begin
               match_in = '0;
            end else if (match_ff == hjcsp_pkg::BLANK_LAST) begin
               match_in = '0;
               phase_in = hjcsp_pkg::PH_JSON;
            end else begin
               match_in = match_ff + 5'd1;
            end
         end
         hjcsp_pkg::PH_JSON: begin
            res[0].out_byte = c;
            res_count       = 3'd1;
            hit = (match_ff <= hjcsp_pkg::MARKER_LAST) &&
                  (c == hjcsp_pkg::marker_char(match_ff));
            if (!hit) begin
               match_in = '0;
            end else if (match_ff == hjcsp_pkg::MARKER_LAST) begin
               // close the array and both enclosing objects
               res[1].out_byte = hjcsp_pkg::CH_RBRACK;
               res[2].out_byte = hjcsp_pkg::CH_RBRACE;
               res[3].out_byte = hjcsp_pkg::CH_RBRACE;
               res_count       = 3'd4;
               match_in        = '0;
               field_in        = '0;
               phase_in        = hjcsp_pkg::PH_CSV;
            end else begin
               match_in = match_ff + 5'd1;
            end
         end
         hjcsp_pkg::PH_CSV: begin
            unique case (csv_phase_ff)
               hjcsp_pkg::CSV_KEY_OPEN: begin
                  if (c == hjcsp_pkg::CH_RBRACK) begin
                     phase_in = hjcsp_pkg::PH_DONE;
                  end
                  if (c == hjcsp_pkg::CH_QUOTE) begin
                     csv_phase_in = hjcsp_pkg::CSV_IN_KEY;
                  end
               end
               hjcsp_pkg::CSV_IN_KEY: begin
                  if (c == hjcsp_pkg::CH_QUOTE) begin
                     csv_phase_in = hjcsp_pkg::CSV_COLON;
                  end
               end
               hjcsp_pkg::CSV_COLON: begin
                  if (c == hjcsp_pkg::CH_COLON) begin
                     csv_phase_in = hjcsp_pkg::CSV_IN_VALUE;
                     esc_in       = 1'b0;
                     if (field_ff >= hjcsp_pkg::FIELD_NEWLINE) begin
                        pre_emit = 1'b1;
                        pre_byte = hjcsp_pkg::CH_LF;
                        field_in = '0;
                     end else if (value_end_ff == hjcsp_pkg::VALUE_END_QUOTE) begin
                        pre_emit = 1'b1;
                        pre_byte = hjcsp_pkg::CH_COMMA;
                     end
                     value_end_in = hjcsp_pkg::VALUE_END_NONE;
                  end
               end
               default: begin
                  stop = (value_end_ff == hjcsp_pkg::VALUE_END_QUOTE) ?
                         hjcsp_pkg::CH_QUOTE : hjcsp_pkg::CH_COMMA;
                  if (value_end_ff == hjcsp_pkg::VALUE_END_NONE) begin
                     value_end_in = (c == hjcsp_pkg::CH_QUOTE) ?
                                    hjcsp_pkg::VALUE_END_QUOTE : hjcsp_pkg::VALUE_END_COMMA;
                     o = c;
                  end else if (!esc_ff && c == hjcsp_pkg::CH_BSLASH) begin
                     esc_in = 1'b1;
                  end else if (esc_ff) begin
                     // escaped quote is doubled; in the dropped field a single quote still goes out
                     esc_in = 1'b0;
                     if (c == hjcsp_pkg::CH_QUOTE) begin
                        pre_emit = 1'b1;
                        pre_byte = hjcsp_pkg::CH_QUOTE;
                     end
                     o = c;
                  end else if (c == stop) begin
                     if (field_ff != hjcsp_pkg::FIELD_DROPPED) begin
                        o = c;
                     end
                     csv_phase_in = hjcsp_pkg::CSV_KEY_OPEN;
                     if (field_ff == hjcsp_pkg::FIELD_LAST) begin
                        field_in = hjcsp_pkg::FIELD_NEWLINE;
                     end else if (field_ff >= hjcsp_pkg::FIELD_NEWLINE) begin
                        field_in = '0;
                     end else begin
                        field_in = field_ff + 3'd1;
                     end
                  end else begin
                     o = c;
                  end
               end
            endcase

            // field test uses the updated field number
            o_emit = (o != '0) && (field_in != hjcsp_pkg::FIELD_DROPPED);
            res[0].channel  = 1'b1;
            res[1].channel  = 1'b1;
            res[0].out_byte = pre_emit ? pre_byte : o;
            res[1].out_byte = o;
            res_count       = {1'b0, pre_emit && o_emit, pre_emit ^ o_emit};
         end
         default: begin
            // done, halted: byte is swallowed
         end
      endcase

      for (int k = 0; k < hjcsp_pkg::MAX_RESULTS; k++) begin
         res[k].last = (3'(k) == res_count - 3'd1);
      end
   end

   // State update on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= hjcsp_pkg::PH_PREFIX;
         match_ff     <= '0;
         field_ff     <= '0;
         csv_phase_ff <= hjcsp_pkg::CSV_KEY_OPEN;
         value_end_ff <= hjcsp_pkg::VALUE_END_NONE;
         esc_ff       <= 1'b0;
      end else if (req_accept) begin
         phase_ff     <= phase_in;
         match_ff     <= match_in;
         field_ff     <= field_in;
         csv_phase_ff <= csv_phase_in;
         value_end_ff <= value_end_in;
         esc_ff       <= esc_in;
      end
   end

   // Queue pointers and fill level
   always_comb begin
      push_count = req_accept ? res_count : 3'd0;
      wr_ptr_in  = wr_ptr_ff + push_count[AW-1:0];
      rd_ptr_in  = rd_ptr_ff + AW'(rsp_pop);
      count_in   = count_ff + (AW+1)'(push_count) - (AW+1)'(rsp_pop);
      for (int k = 0; k < hjcsp_pkg::MAX_RESULTS; k++) begin
         wr_addr[k] = wr_ptr_ff + AW'(k);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage: up to four writes per cycle
   always_ff @(posedge clock) begin
      for (int k = 0; k < hjcsp_pkg::MAX_RESULTS; k++) begin
         if (3'(k) < push_count) begin
            queue_mem[wr_addr[k]] <= res[k];
         end
      end
   end

   assign rsp_out_byte = queue_mem[rd_ptr_ff].out_byte;
   assign rsp_channel  = queue_mem[rd_ptr_ff].channel;
   assign rsp_status   = queue_mem[rd_ptr_ff].status;
   assign rsp_last     = queue_mem[rd_ptr_ff].last;

`ifndef SYNTHESIS
   // queue never overflows
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(hjcsp_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   // a halted or finished parser produces nothing
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (phase_ff == hjcsp_pkg::PH_HALT || phase_ff == hjcsp_pkg::PH_DONE))
      |-> (push_count == 3'd0))
      else $error("results after end of parse");

   // an error result sends the parser to the halted phase
   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && push_count != 3'd0 && res[0].status) |=> (phase_ff == hjcsp_pkg::PH_HALT))
      else $error("error result without halt");
`endif

endmodule

// File: dv/hjcsp_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts the characters each accepted byte produces
// and compares every result transfer against the oldest prediction.
module hjcsp_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_channel,
   input  logic       rsp_status,
   input  logic       rsp_last,
   output int         error_count,
   output int         chars_owed
);

   // Literals the stream must match, first character in the top byte
   localparam logic [8*9-1:0]  STATUS_TEXT = "HTTP/1.1 ";
   localparam logic [8*4-1:0]  BLANK_TEXT  = {8'h0D, 8'h0A, 8'h0D, 8'h0A};
   localparam logic [8*17-1:0] MARKER_TEXT = ",\"transactions\":[";

   localparam logic [2:0] FIELD_FIRST   = 3'd0;
   localparam logic       CHAN_JSON     = 1'b0;
   localparam logic       CHAN_CSV      = 1'b1;
   localparam logic       ST_DATA       = 1'b0;
   localparam logic       ST_BAD_PREFIX = 1'b1;

   // Parser state mirror
   hjcsp_pkg::phase_type     parse_phase;
   hjcsp_pkg::csv_phase_type pair_phase;
   logic [4:0]               match_pos;
   logic [2:0]               field_idx;
   logic [1:0]               value_end;
   logic                     escaped;

   hjcsp_pkg::rsp_entry_type byte_chars [$];      // characters from the byte in hand
   hjcsp_pkg::rsp_entry_type expected_chars [$];  // characters still to come out

   // Queue one character for the byte in hand; at most four per byte
   function automatic void add_char(input logic [7:0] ch, input logic chan, input logic err);
      hjcsp_pkg::rsp_entry_type e;
      if (byte_chars.size() < hjcsp_pkg::MAX_RESULTS) begin
         e.out_byte = ch;
         e.channel  = chan;
         e.status   = err;
         e.last     = 1'b0;
         byte_chars.push_back(e);
      end
   endfunction

   // Advance the parser by one byte and queue what it emits
   function automatic void parse_byte(input logic [7:0] c);
      logic [7:0]               kept;
      logic [7:0]               stop_char;
      logic                     hit;
      hjcsp_pkg::rsp_entry_type tail;
      kept = 8'h00;
      byte_chars.delete();
      case (parse_phase)
         hjcsp_pkg::PH_PREFIX: begin
            hit = (match_pos <= hjcsp_pkg::PREFIX_LAST) &&
                  (c == STATUS_TEXT[8*(hjcsp_pkg::PREFIX_LAST - match_pos) +: 8]);
            if (!hit) begin
               add_char(8'h00, CHAN_JSON, ST_BAD_PREFIX);
               parse_phase = hjcsp_pkg::PH_HALT;
            end else if (match_pos == hjcsp_pkg::PREFIX_LAST) begin
               match_pos   = 5'd0;
               parse_phase = hjcsp_pkg::PH_HEADER;
            end else begin
               match_pos = match_pos + 5'd1;
            end
         end
         hjcsp_pkg::PH_HEADER: begin
            hit = (match_pos <= hjcsp_pkg::BLANK_LAST) &&
                  (c == BLANK_TEXT[8*(hjcsp_pkg::BLANK_LAST - match_pos) +: 8]);
            if (!hit) begin
               match_pos = 5'd0;
            end else if (match_pos == hjcsp_pkg::BLANK_LAST) begin
               match_pos   = 5'd0;
               parse_phase = hjcsp_pkg::PH_JSON;
            end else begin
               match_pos = match_pos + 5'd1;
            end
         end
         hjcsp_pkg::PH_JSON: begin
            add_char(c, CHAN_JSON, ST_DATA);
            hit = (match_pos <= hjcsp_pkg::MARKER_LAST) &&
                  (c == MARKER_TEXT[8*(hjcsp_pkg::MARKER_LAST - match_pos) +: 8]);
            if (!hit) begin
               match_pos = 5'd0;
            end else if (match_pos == hjcsp_pkg::MARKER_LAST) begin
               // close the array and both enclosing objects
               add_char(hjcsp_pkg::CH_RBRACK, CHAN_JSON, ST_DATA);
               add_char(hjcsp_pkg::CH_RBRACE, CHAN_JSON, ST_DATA);
               add_char(hjcsp_pkg::CH_RBRACE, CHAN_JSON, ST_DATA);
               match_pos   = 5'd0;
               field_idx   = FIELD_FIRST;
               parse_phase = hjcsp_pkg::PH_CSV;
            end else begin
               match_pos = match_pos + 5'd1;
            end
         end
         hjcsp_pkg::PH_CSV: begin
            case (pair_phase)
               hjcsp_pkg::CSV_KEY_OPEN: begin
                  if (c == hjcsp_pkg::CH_RBRACK) parse_phase = hjcsp_pkg::PH_DONE;
                  if (c == hjcsp_pkg::CH_QUOTE) pair_phase = hjcsp_pkg::CSV_IN_KEY;
               end
               hjcsp_pkg::CSV_IN_KEY: begin
                  if (c == hjcsp_pkg::CH_QUOTE) pair_phase = hjcsp_pkg::CSV_COLON;
               end
               hjcsp_pkg::CSV_COLON: begin
                  if (c == hjcsp_pkg::CH_COLON) begin
                     pair_phase = hjcsp_pkg::CSV_IN_VALUE;
                     escaped    = 1'b0;
                     if (field_idx >= hjcsp_pkg::FIELD_NEWLINE) begin
                        add_char(hjcsp_pkg::CH_LF, CHAN_CSV, ST_DATA);
                        field_idx = FIELD_FIRST;
                     end else if (value_end == hjcsp_pkg::VALUE_END_QUOTE) begin
                        add_char(hjcsp_pkg::CH_COMMA, CHAN_CSV, ST_DATA);
                     end
                     value_end = hjcsp_pkg::VALUE_END_NONE;
                  end
               end
               default: begin
                  stop_char = (value_end == hjcsp_pkg::VALUE_END_QUOTE) ?
                              hjcsp_pkg::CH_QUOTE : hjcsp_pkg::CH_COMMA;
                  if (value_end == hjcsp_pkg::VALUE_END_NONE) begin
                     value_end = (c == hjcsp_pkg::CH_QUOTE) ?
                                 hjcsp_pkg::VALUE_END_QUOTE : hjcsp_pkg::VALUE_END_COMMA;
                     kept      = c;
                  end else if (!escaped && c == hjcsp_pkg::CH_BSLASH) begin
                     escaped = 1'b1;
                  end else if (escaped) begin
                     // escaped quote goes out doubled; in the dropped field a single one still goes out
                     escaped = 1'b0;
                     if (c == hjcsp_pkg::CH_QUOTE) add_char(hjcsp_pkg::CH_QUOTE, CHAN_CSV, ST_DATA);
                     kept = c;
                  end else if (c == stop_char) begin
                     if (field_idx != hjcsp_pkg::FIELD_DROPPED) kept = c;
                     pair_phase = hjcsp_pkg::CSV_KEY_OPEN;
                     if (field_idx == hjcsp_pkg::FIELD_LAST) field_idx = hjcsp_pkg::FIELD_NEWLINE;
                     else if (field_idx >= hjcsp_pkg::FIELD_NEWLINE) field_idx = FIELD_FIRST;
                     else field_idx = field_idx + 3'd1;
                  end else begin
                     kept = c;
                  end
               end
            endcase
            // zero bytes never reach the CSV output; field index is the updated one
            if (kept != 8'h00 && field_idx != hjcsp_pkg::FIELD_DROPPED) begin
               add_char(kept, CHAN_CSV, ST_DATA);
            end
         end
         default: ;
      endcase
      if (byte_chars.size() > 0) begin
         tail      = byte_chars.pop_back();
         tail.last = 1'b1;
         byte_chars.push_back(tail);
         foreach (byte_chars[i]) expected_chars.push_back(byte_chars[i]);
      end
   endfunction

   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s expected %02h, got %02h", $time, name, want, got);
      end
   endfunction

   // Transfers are taken from the values present at the rising edge
   always @(posedge clock) begin : sample
      hjcsp_pkg::rsp_entry_type want;
      if (reset) begin
         parse_phase = hjcsp_pkg::PH_PREFIX;
         pair_phase  = hjcsp_pkg::CSV_KEY_OPEN;
         match_pos   = 5'd0;
         field_idx   = FIELD_FIRST;
         value_end   = hjcsp_pkg::VALUE_END_NONE;
         escaped     = 1'b0;
         expected_chars.delete();
      end else begin
         if (req_valid && req_ready) parse_byte(req_in_byte);
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result transfer, expected none, %s",
                        $time, $sformatf("got %02h ch %0b st %0b last %0b",
                        rsp_out_byte, rsp_channel, rsp_status, rsp_last));
            end else begin
               want = expected_chars.pop_front();
               compare_field("out_byte", want.out_byte, rsp_out_byte);
               compare_field("channel", {7'd0, want.channel}, {7'd0, rsp_channel});
               compare_field("status", {7'd0, want.status}, {7'd0, rsp_status});
               compare_field("last", {7'd0, want.last}, {7'd0, rsp_last});
            end
         end
      end
      chars_owed = expected_chars.size();
   end

endmodule

// File: dv/http_json_to_csv_stream_parser_tb.sv
`timescale 1ns / 1ps

module http_json_to_csv_stream_parser_tb;

   localparam int CYCLE_LIMIT       = 30000;
   localparam int IDLE_PERCENT      = 17;
   localparam int HOLD_AFTER        = 12;   // results taken before the long hold-off
   localparam int HOLD_OFF_CYCLES   = 80;
   localparam int CALM_REQ_FROM     = 70;   // byte window with a steady sender
   localparam int CALM_REQ_TO       = 140;
   localparam int CALM_RSP_FROM     = 30;   // result window with a steady sink
   localparam int CALM_RSP_TO       = 100;
   localparam int DRAIN_CYCLES      = 30;
   localparam int RECORDS           = 2;
   localparam int FIELDS_PER_RECORD = 6;
   localparam logic [7:0] CH_CR     = 8'h0D;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic       rsp_channel;
   logic       rsp_status;
   logic       rsp_last;

   int         fail_count;
   int         chars_owed;
   int         cycle_count;
   int         bytes_sent;
   int         chars_taken;
   logic [7:0] response [$];

   http_json_to_csv_stream_parser dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_channel  (rsp_channel),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

   hjcsp_checker chk (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_channel  (rsp_channel),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last),
      .error_count  (fail_count),
      .chars_owed   (chars_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // Result transfers seen so far, for the sink's pacing
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) chars_taken++;
   end

   function automatic void put_byte(input logic [7:0] b);
      response.push_back(b);
   endfunction

   function automatic void put_text(input string s);
      for (int i = 0; i < s.len(); i++) response.push_back(s[i]);
   endfunction

   // Header line of random bytes, never CR or LF, then CR LF
   function automatic void put_header_line();
      int         n;
      logic [7:0] ch;
      n = $urandom_range(6, 2);
      for (int i = 0; i < n; i++) begin
         do ch = 8'($urandom_range(255)); while (ch == CH_CR || ch == hjcsp_pkg::CH_LF);
         put_byte(ch);
      end
      put_byte(CH_CR);
      put_byte(hjcsp_pkg::CH_LF);
   endfunction

   // JSON filler that cannot start a marker by accident
   function automatic void put_json_noise(input int n);
      logic [7:0] ch;
      for (int i = 0; i < n; i++) begin
         do ch = 8'($urandom_range(255)); while (ch == hjcsp_pkg::CH_COMMA);
         put_byte(ch);
      end
   endfunction

   // One value, quoted or bare, with escapes, zero bytes and the odd stray byte
   function automatic bit put_value();
      bit         quoted;
      int         n;
      int         pick;
      logic [7:0] ch;
      quoted = 1'($urandom_range(1));
      n      = quoted ? $urandom_range(3) : $urandom_range(3, 1);
      if (quoted) put_byte(hjcsp_pkg::CH_QUOTE);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            put_byte(hjcsp_pkg::CH_BSLASH);
            case ($urandom_range(3))
               0:       put_byte(hjcsp_pkg::CH_QUOTE);
               1:       put_byte(hjcsp_pkg::CH_BSLASH);
               2:       put_byte(8'h00);
               default: put_byte(8'($urandom_range(255)));
            endcase
         end else if (pick < 20) begin
            put_byte(8'h00);
         end else if (pick < 24) begin
            put_byte(8'($urandom_range(255)));
         end else if (quoted) begin
            do ch = 8'($urandom_range(255, 1));
            while (ch == hjcsp_pkg::CH_QUOTE || ch == hjcsp_pkg::CH_BSLASH);
            put_byte(ch);
         end else begin
            put_byte(8'("0" + $urandom_range(9)));
         end
      end
      if (quoted) put_byte(hjcsp_pkg::CH_QUOTE);
      return quoted;
   endfunction

   // One transaction object; tells whether its last value was quoted
   function automatic bit put_record();
      bit quoted;
      int klen;
      quoted = 1'b0;
      put_byte("{");
      for (int f = 0; f < FIELDS_PER_RECORD; f++) begin
         if (f > 0) put_byte(hjcsp_pkg::CH_COMMA);
         put_byte(hjcsp_pkg::CH_QUOTE);
         klen = $urandom_range(2, 1);
         for (int k = 0; k < klen; k++) begin
            if ($urandom_range(99) < 5) put_byte(8'($urandom_range(255)));
            else put_byte(8'("a" + $urandom_range(25)));
         end
         put_byte(hjcsp_pkg::CH_QUOTE);
         put_byte(hjcsp_pkg::CH_COLON);
         quoted = put_value();
      end
      put_byte(hjcsp_pkg::CH_RBRACE);
      return quoted;
   endfunction

   function automatic void build_response();
      bit quoted;
      quoted = 1'b1;
      // status line and headers, with near misses of the blank line
      put_text("HTTP/1.1 ");
      put_text("X:");
      put_byte(8'h00);
      put_byte(8'hFF);
      put_byte(CH_CR);
      put_byte(hjcsp_pkg::CH_LF);
      put_byte(CH_CR);          // mismatching CR must not restart the match
      put_byte(CH_CR);
      put_byte(hjcsp_pkg::CH_LF);
      put_header_line();
      put_byte(CH_CR);          // blank line broken after three of its bytes
      put_header_line();
      put_header_line();
      put_byte(CH_CR);
      put_byte(hjcsp_pkg::CH_LF);
      // JSON body with broken markers ahead of the real one
      put_text("{\"id\":1,\"result\":{");
      put_json_noise(6);
      put_text(",\"trans");
      put_json_noise(3);
      put_text(",,\"transactions\":[");
      put_json_noise(4);
      put_text(",\"transactions\":[");
      // transaction records
      for (int r = 0; r < RECORDS; r++) begin
         if (r > 0) put_byte(hjcsp_pkg::CH_COMMA);
         quoted = put_record();
      end
      if (!quoted) put_byte(hjcsp_pkg::CH_COMMA);   // a bare last value needs its comma
      put_byte(hjcsp_pkg::CH_RBRACK);
      // trailing bytes the parser ignores
      put_text("}}");
      put_byte(hjcsp_pkg::CH_QUOTE);
      put_byte(hjcsp_pkg::CH_COLON);
      put_byte(8'hFF);
   endfunction

   // Sender: reset, then one transfer per response byte
   initial begin : stimulus
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_byte = 8'h00;
      build_response();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (response[i]) begin
         while (!(bytes_sent >= CALM_REQ_FROM && bytes_sent < CALM_REQ_TO) &&
                $urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid   <= 1'b1;
         req_in_byte <= response[i];
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         bytes_sent++;
         @(negedge clock);
      end
      req_valid <= 1'b0;
      // drain, then allow time for stray results
      while (chars_owed != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && chars_owed == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Sink: random stalls, one long hold-off early in the JSON copy, a steady stretch
   initial begin : sink
      int hold_left;
      bit held;
      hold_left = 0;
      held      = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!held && chars_taken >= HOLD_AFTER) begin
            held      = 1'b1;
            hold_left = HOLD_OFF_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (chars_taken >= CALM_RSP_FROM && chars_taken < CALM_RSP_TO) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

endmodule

// File: sim.f
sv/hjcsp_pkg.sv
sv/http_json_to_csv_stream_parser.sv
dv/hjcsp_checker.sv
dv/http_json_to_csv_stream_parser_tb.sv
